// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/blpg_pkg.sv =====
// shared types and constants for the line pixel generator
`default_nettype none

package blpg_pkg;

    localparam int BLPG_COORD_BITS = 12;

    // command codes of an input item
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch endpoints and raw deltas
        logic setup;    // build line state, emit start result
        logic step;     // emit one pixel and advance
        logic idle_nxt; // next item with no line running
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic line_active;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/blpg_ctrl.sv =====
// controller state machine: accepts items and sequences the datapath
`default_nettype none

module blpg_ctrl import blpg_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic     i_command,
    input  wire t_dp_stat i_stat,
    output logic          busy,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SETUP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = start && !busy;

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_START) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_SETUP;
                    end else if (i_stat.line_active) begin
                        o_cmd.step = 1'b1;
                    end else begin
                        o_cmd.idle_nxt = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                busy        = 1'b1;
                o_cmd.setup = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/blpg_datapath.sv =====
// datapath: endpoint setup, error-term stepping and result registers
`default_nettype none

module blpg_datapath import blpg_pkg::*; #(
    parameter int COORD_BITS = BLPG_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    output t_dp_stat                          o_stat,
    output logic                              o_result_valid,
    output logic                              o_pixel_valid,
    output logic                              o_last,
    output logic signed [COORD_BITS-1:0]      o_pixel_x,
    output logic signed [COORD_BITS-1:0]      o_pixel_y,
    output logic        [COORD_BITS-1:0]      o_step_index,
    output logic        [COORD_BITS-1:0]      o_step_total,
    output logic                              o_colors_swapped
);

    localparam int N = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    // captured endpoints and raw deltas
    logic signed [N-1:0] r_x0, r_y0, r_x1, r_y1;
    logic        [N:0]   r_dx, r_dy;

    // line state
    logic signed [N-1:0] r_cur_x, r_cur_y, r_major_end;
    logic signed [E-1:0] r_err;
    logic        [N-1:0] r_major_delta, r_minor_delta, r_cnt;
    logic                r_minor_dir, r_y_major, r_line_active, r_swapped;

    // result registers
    logic                r_out_valid, r_out_pix, r_out_last, r_out_swapped;
    logic signed [N-1:0] r_out_x, r_out_y;
    logic        [N-1:0] r_out_idx, r_out_total;

    // setup terms
    logic [N:0]          w_ndx, w_ndy;
    logic [N-1:0]        w_adx, w_ady, w_major, w_minor;
    logic                w_y_major, w_dx_pos, w_dy_pos, w_swap, w_minor_dir;
    logic signed [N-1:0] w_sx, w_sy, w_send;
    logic signed [E-1:0] w_err0;

    // step terms
    logic [N:0]          w_cnt_next;
    logic                w_last, w_err_pos;
    logic signed [N-1:0] w_minor_cur, w_minor_next, w_major_cur, w_major_next;
    logic signed [E-1:0] w_two_minor, w_two_major, w_err_next;

    assign o_stat.line_active = r_line_active;

    always_comb begin
        w_ndx    = -r_dx;
        w_ndy    = -r_dy;
        w_adx    = r_dx[N] ? w_ndx[N-1:0] : r_dx[N-1:0];
        w_ady    = r_dy[N] ? w_ndy[N-1:0] : r_dy[N-1:0];
        w_y_major = !(w_ady < w_adx);
        w_dx_pos = !r_dx[N] && (r_dx != '0);
        w_dy_pos = !r_dy[N] && (r_dy != '0);
        // endpoints run backwards when the major delta is not positive
        w_swap   = w_y_major ? !w_dy_pos : !w_dx_pos;
        if (w_y_major) begin
            w_minor_dir = w_swap ? w_dx_pos : r_dx[N];
            w_major     = w_ady;
            w_minor     = w_adx;
            w_send      = w_swap ? r_y0 : r_y1;
        end else begin
            w_minor_dir = w_swap ? w_dy_pos : r_dy[N];
            w_major     = w_adx;
            w_minor     = w_ady;
            w_send      = w_swap ? r_x0 : r_x1;
        end
        w_sx   = w_swap ? r_x1 : r_x0;
        w_sy   = w_swap ? r_y1 : r_y0;
        w_err0 = signed'({2'b00, w_minor, 1'b0} - {3'b000, w_major});
    end

    always_comb begin
        w_cnt_next   = {1'b0, r_cnt} + {{N{1'b0}}, 1'b1};
        w_last       = w_cnt_next >= {1'b0, r_major_delta};
        w_err_pos    = !r_err[E-1] && (r_err != '0);
        w_minor_cur  = r_y_major ? r_cur_x : r_cur_y;
        w_major_cur  = r_y_major ? r_cur_y : r_cur_x;
        w_major_next = w_major_cur + N'(1);
        if (!w_err_pos) begin
            w_minor_next = w_minor_cur;
        end else if (r_minor_dir) begin
            w_minor_next = w_minor_cur - N'(1);
        end else begin
            w_minor_next = w_minor_cur + N'(1);
        end
        w_two_minor = signed'({2'b00, r_minor_delta, 1'b0});
        w_two_major = signed'({2'b00, r_major_delta, 1'b0});
        w_err_next  = r_err + w_two_minor - (w_err_pos ? w_two_major : E'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x0 <= i_start_x;
            r_y0 <= i_start_y;
            r_x1 <= i_end_x;
            r_y1 <= i_end_y;
            r_dx <= {i_end_x[N-1], i_end_x} - {i_start_x[N-1], i_start_x};
            r_dy <= {i_end_y[N-1], i_end_y} - {i_start_y[N-1], i_start_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_major_end   <= '0;
            r_err         <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_cnt         <= '0;
            r_minor_dir   <= 1'b0;
            r_y_major     <= 1'b0;
            r_line_active <= 1'b0;
            r_swapped     <= 1'b0;
        end else if (i_cmd.setup) begin
            r_cur_x       <= w_sx;
            r_cur_y       <= w_sy;
            r_major_end   <= w_send;
            r_err         <= w_err0;
            r_major_delta <= w_major;
            r_minor_delta <= w_minor;
            r_cnt         <= '0;
            r_minor_dir   <= w_minor_dir;
            r_y_major     <= w_y_major;
            r_line_active <= (w_major != '0);
            r_swapped     <= w_swap;
        end else if (i_cmd.step) begin
            r_cnt <= w_cnt_next[N-1:0];
            r_err <= w_err_next;
            if (r_y_major) begin
                r_cur_x <= w_minor_next;
                r_cur_y <= w_major_next;
            end else begin
                r_cur_x <= w_major_next;
                r_cur_y <= w_minor_next;
            end
            r_line_active <= !(w_last || (w_major_next == r_major_end));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.setup || i_cmd.step || i_cmd.idle_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_out_pix     <= 1'b0;
            r_out_last    <= (w_major == '0);
            r_out_x       <= w_sx;
            r_out_y       <= w_sy;
            r_out_idx     <= '0;
            r_out_total   <= w_major;
            r_out_swapped <= w_swap;
        end else if (i_cmd.step) begin
            r_out_pix     <= 1'b1;
            r_out_last    <= w_last;
            r_out_x       <= r_cur_x;
            r_out_y       <= r_cur_y;
            r_out_idx     <= r_cnt;
            r_out_total   <= r_major_delta;
            r_out_swapped <= r_swapped;
        end else if (i_cmd.idle_nxt) begin
            r_out_pix     <= 1'b0;
            r_out_last    <= 1'b0;
            r_out_x       <= '0;
            r_out_y       <= '0;
            r_out_idx     <= '0;
            r_out_total   <= r_major_delta;
            r_out_swapped <= r_swapped;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_pixel_valid    = r_out_pix;
    assign o_last           = r_out_last;
    assign o_pixel_x        = r_out_x;
    assign o_pixel_y        = r_out_y;
    assign o_step_index     = r_out_idx;
    assign o_step_total     = r_out_total;
    assign o_colors_swapped = r_out_swapped;

endmodule

`default_nettype wire

// ===== src/bresenham_line_pixel_generator.sv =====
// next item: result strobed in the cycle after acceptance, one pixel per clock sustained
// start item: endpoint deltas registered then line setup; busy for one cycle
// results leave through the output register and cannot be stalled by the receiver
// a running line is abandoned by a new start item
// synchronous active-low reset returns to idle with no line and zeroed line state
`default_nettype none

`include "assert_macros.svh"

module bresenham_line_pixel_generator import blpg_pkg::*; #(
    parameter int COORD_BITS = BLPG_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_command,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    output logic                              o_result_valid,
    output logic                              o_pixel_valid,
    output logic                              o_last,
    output logic signed [COORD_BITS-1:0]      o_pixel_x,
    output logic signed [COORD_BITS-1:0]      o_pixel_y,
    output logic        [COORD_BITS-1:0]      o_step_index,
    output logic        [COORD_BITS-1:0]      o_step_total,
    output logic                              o_colors_swapped
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_start_acc;
    logic     w_next_acc;
    logic     w_pixel_out;

    blpg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .busy      (busy),
        .o_cmd     (w_cmd)
    );

    blpg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .o_stat           (w_stat),
        .o_result_valid   (o_result_valid),
        .o_pixel_valid    (o_pixel_valid),
        .o_last           (o_last),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_step_index     (o_step_index),
        .o_step_total     (o_step_total),
        .o_colors_swapped (o_colors_swapped)
    );

    assign w_start_acc = start && !busy && (i_command == CMD_START);
    assign w_next_acc  = start && !busy && (i_command == CMD_NEXT);
    assign w_pixel_out = o_result_valid && o_pixel_valid;

    // start item holds the port for its setup cycle and gives no result yet
    `ASSERT_NEXT(a_start_setup, i_clk, i_rst_n, w_start_acc, busy && !o_result_valid)
    // next item always gives its result in the following cycle
    `ASSERT_NEXT(a_next_result, i_clk, i_rst_n, w_next_acc, o_result_valid)
    // setup never lasts more than one cycle
    `ASSERT_NEXT(a_busy_short, i_clk, i_rst_n, busy, !busy)
    // an emitted pixel always lies inside the line's step range
    `ASSERT_SAME(a_index_range, i_clk, i_rst_n, w_pixel_out, o_step_index < o_step_total)

endmodule

`default_nettype wire

// ===== tb/bresenham_line_pixel_generator_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the bresenham line pixel generator
module bresenham_line_pixel_generator_tb;
    import blpg_pkg::*;

    localparam int CW          = BLPG_COORD_BITS;
    localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (CW - 1));
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 560;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic          pixel_valid;
        logic          last;
        logic [CW-1:0] pixel_x;
        logic [CW-1:0] pixel_y;
        logic [CW-1:0] step_index;
        logic [CW-1:0] step_total;
        logic          colors_swapped;
    } t_pixel;

    typedef struct {
        logic   cmd;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        bit     typed;
        t_pixel res;
    } t_script_row;

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   start     = 1'b0;
    logic   i_command = CMD_START;
    t_coord i_start_x = '0;
    t_coord i_start_y = '0;
    t_coord i_end_x   = '0;
    t_coord i_end_y   = '0;
    logic   busy;
    logic   o_result_valid;
    logic   o_pixel_valid;
    logic   o_last;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic [CW-1:0] o_step_index;
    logic [CW-1:0] o_step_total;
    logic   o_colors_swapped;

    t_pixel      pixel_queue[$];
    t_script_row line_script[$];
    int          mismatches    = 0;
    int          cycle_cnt     = 0;
    int          items_sent    = 0;
    int          send_idle_pct = 0;

    // line state of the predictor
    int line_x, line_y, line_end, err_acc, run_len, rise, step_cnt;
    bit minor_down, steep, drawing, swapped;

    bresenham_line_pixel_generator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .o_result_valid   (o_result_valid),
        .o_pixel_valid    (o_pixel_valid),
        .o_last           (o_last),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_step_index     (o_step_index),
        .o_step_total     (o_step_total),
        .o_colors_swapped (o_colors_swapped)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_pixel mk_res(bit pv, bit lst, int x, int y, int idx, int tot, bit sw);
        t_pixel r;
        r.pixel_valid    = pv;
        r.last           = lst;
        r.pixel_x        = x[CW-1:0];
        r.pixel_y        = y[CW-1:0];
        r.step_index     = idx[CW-1:0];
        r.step_total     = tot[CW-1:0];
        r.colors_swapped = sw;
        return r;
    endfunction

    function automatic t_coord rnd_coord();
        return t_coord'($urandom_range((1 << CW) - 1));
    endfunction

    function automatic t_coord clamp_coord(int v);
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        if (v < COORD_MIN) return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    function void add_row(logic cmd, int sx, int sy, int ex, int ey, bit typed, t_pixel res);
        t_script_row row;
        row.cmd   = cmd;
        row.sx    = t_coord'(sx);
        row.sy    = t_coord'(sy);
        row.ex    = t_coord'(ex);
        row.ey    = t_coord'(ey);
        row.typed = typed;
        row.res   = res;
        line_script.push_back(row);
    endfunction

    // works out the result of one item and advances the line state
    task automatic raster_predict(input logic cmd, input t_coord sx, sy, ex, ey,
                                  output t_pixel r);
        int x0, y0, x1, y1, adx, ady, t;
        if (cmd == CMD_START) begin
            x0 = sx;
            y0 = sy;
            x1 = ex;
            y1 = ey;
            adx = (x1 < x0) ? x0 - x1 : x1 - x0;
            ady = (y1 < y0) ? y0 - y1 : y1 - y0;
            // ties go to the y axis
            steep   = !(ady < adx);
            swapped = steep ? !(y0 < y1) : !(x0 < x1);
            if (swapped) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            line_x = x0;
            line_y = y0;
            if (steep) begin
                line_end   = y1;
                run_len    = ady;
                rise       = adx;
                minor_down = (x1 - x0) < 0;
            end else begin
                line_end   = x1;
                run_len    = adx;
                rise       = ady;
                minor_down = (y1 - y0) < 0;
            end
            err_acc  = 2 * rise - run_len;
            step_cnt = 0;
            drawing  = run_len != 0;
            r = mk_res(1'b0, !drawing, line_x, line_y, 0, run_len, swapped);
        end else if (!drawing) begin
            r = mk_res(1'b0, 1'b0, 0, 0, 0, run_len, swapped);
        end else begin
            r = mk_res(1'b1, step_cnt + 1 >= run_len, line_x, line_y, step_cnt, run_len,
                       swapped);
            step_cnt++;
            if (err_acc > 0) begin
                if (steep) line_x += minor_down ? -1 : 1;
                else line_y += minor_down ? -1 : 1;
                err_acc += 2 * (rise - run_len);
            end else begin
                err_acc += 2 * rise;
            end
            if (steep) line_y++;
            else line_x++;
            if (step_cnt >= run_len || (steep ? line_y : line_x) == line_end) drawing = 1'b0;
        end
    endtask

    task automatic send_item(input logic cmd, input t_coord sx, sy, ex, ey,
                             input bit typed, input t_pixel typed_res);
        t_pixel pred;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        do @(posedge i_clk); while (busy);
        raster_predict(cmd, sx, sy, ex, ey, pred);
        pixel_queue.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    task automatic run_line(input t_coord sx, sy, ex, ey, input int nexts);
        send_item(CMD_START, sx, sy, ex, ey, 1'b0, '0);
        repeat (nexts) send_item(CMD_NEXT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                                 1'b0, '0);
    endtask

    // holds the sender off until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic cmp(input string name, input logic [CW-1:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%h, got 0x%h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_result_valid) begin
            if (pixel_queue.size() == 0) begin
                $error("result with no item pending");
                mismatches++;
            end else begin
                want = pixel_queue.pop_front();
                cmp("pixel_valid", want.pixel_valid, o_pixel_valid);
                cmp("last", want.last, o_last);
                cmp("pixel_x", want.pixel_x, o_pixel_x);
                cmp("pixel_y", want.pixel_y, o_pixel_y);
                cmp("step_index", want.step_index, o_step_index);
                cmp("step_total", want.step_total, o_step_total);
                cmp("colors_swapped", want.colors_swapped, o_colors_swapped);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int     ph, kind, dx, dy, len, nexts;
        t_coord sx, sy, ex, ey;

        // next item before any line has been started
        add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, mk_res(1'b0, 1'b0, 0, 0, 0, 0, 1'b0));
        // zero-length line: y major, swap test fails, nothing to draw
        add_row(CMD_START, 5, -3, 5, -3, 1'b1, mk_res(1'b0, 1'b1, 5, -3, 0, 0, 1'b1));
        add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, mk_res(1'b0, 1'b0, 0, 0, 0, 0, 1'b1));
        // full-range diagonal, tie goes to y
        add_row(CMD_START, -2048, -2048, 2047, 2047, 1'b1,
                mk_res(1'b0, 1'b0, -2048, -2048, 0, 4095, 1'b0));
        repeat (2) add_row(CMD_NEXT, 0, 0, 0, 0, 1'b0, '0);
        // abandons the running line, runs backwards along x
        add_row(CMD_START, 2047, 0, -2048, 0, 1'b1,
                mk_res(1'b0, 1'b0, -2048, 0, 0, 4095, 1'b1));
        add_row(CMD_NEXT, -1, -1, -1, -1, 1'b0, '0);
        add_row(CMD_START, 0, 0, 5, 2, 1'b0, '0);
        repeat (6) add_row(CMD_NEXT, 0, 0, 0, 0, 1'b0, '0);
        // y major, minor axis decreasing
        add_row(CMD_START, 3, 0, 0, 7, 1'b0, '0);
        repeat (3) add_row(CMD_NEXT, 0, 0, 0, 0, 1'b0, '0);
        // x major, minor axis decreasing
        add_row(CMD_START, 0, 5, 6, 1, 1'b0, '0);
        repeat (2) add_row(CMD_NEXT, 0, 0, 0, 0, 1'b0, '0);
        // single-pixel line, then a next on the finished line
        add_row(CMD_START, 1, 1, 2, 1, 1'b0, '0);
        add_row(CMD_NEXT, 0, 0, 0, 0, 1'b0, '0);
        add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, mk_res(1'b0, 1'b0, 0, 0, 0, 1, 1'b0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        foreach (line_script[k])
            send_item(line_script[k].cmd, line_script[k].sx, line_script[k].sy,
                      line_script[k].ex, line_script[k].ey, line_script[k].typed,
                      line_script[k].res);

        for (ph = 0; ph < 3; ph++) begin
            drain_results();
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 77 : 0;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                kind = $urandom_range(99);
                if (kind < 70) begin
                    // short line drawn out, mostly to its end and a little past
                    sx = rnd_coord();
                    sy = rnd_coord();
                    dx = int'($urandom_range(24)) - 12;
                    dy = int'($urandom_range(24)) - 12;
                    case ($urandom_range(9))
                        0: begin
                            dx = 0;
                            dy = 0;
                        end
                        1: dy = $urandom_range(1) ? dx : -dx;
                        default: ;
                    endcase
                    ex = clamp_coord(int'(sx) + dx);
                    ey = clamp_coord(int'(sy) + dy);
                    dx = int'(ex) - int'(sx);
                    dy = int'(ey) - int'(sy);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    len = (dx > dy) ? dx : dy;
                    nexts = ($urandom_range(4) == 0) ? $urandom_range(len) :
                            len + $urandom_range(2);
                    run_line(sx, sy, ex, ey, nexts);
                end else if (kind < 85) begin
                    run_line(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                             $urandom_range(24));
                end else begin
                    send_item($urandom_range(1) ? CMD_NEXT : CMD_START, rnd_coord(),
                              rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/blpg_pkg.sv
src/blpg_ctrl.sv
src/blpg_datapath.sv
src/bresenham_line_pixel_generator.sv
tb/bresenham_line_pixel_generator_tb.sv
